### rtl/core/neighbor_table_with_aging_core_assert.svh
// assertion macros used by the neighbor table engine rtl
// needs signals named clock and reset in the including module
`ifndef NEIGHBOR_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NTA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define NTA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/nta_pkg.sv
// types and constants of the neighbor table with aging
// no dependencies; used by every module of the block
package nta_pkg;

   // command kinds on the request channel
   localparam logic CMD_HELLO = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_REFRESHED = 2'd0;
   localparam logic [1:0] ST_ADDED     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_TICK      = 2'd3;

   // configuration register indexes and reset values
   localparam int         CSR_AW           = 3;
   localparam logic       REG_TIMEOUT      = 1'b0;
   localparam logic       REG_INTERVAL     = 1'b1;
   localparam logic [7:0] TIMEOUT_RST      = 8'd15;
   localparam logic [7:0] INTERVAL_RST     = 8'd30;

   // stream widths
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 32;

   // saturation limit of the 5 bit counters
   localparam logic [4:0] CNT_MAX = 5'd31;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] timeout;
      logic [7:0] interval;
   } cfg_type;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  ifx;
      logic [31:0] rid;
      logic [31:0] addr;
      logic [31:0] mask;
   } item_type;

   // one table entry as stored in the entry memory
   typedef struct packed {
      logic [1:0]  iface;
      logic [31:0] rid;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [7:0]  heard;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        send;
      logic [15:0] seq;
      logic [4:0]  count;
      logic [4:0]  removed;
   } rsp_type;

endpackage

### rtl/core/nta_entry_mem.sv
// neighbor entry memory: one write port, one read port, registered read data
// depends on nta_pkg for the entry layout
module nta_entry_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  nta_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output nta_pkg::entry_type  rd_data
);

   nta_pkg::entry_type mem_ff [DEPTH];
   nta_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/nta_csr.sv
// apb-style register file: neighbor timeout and lsu interval
// depends on nta_pkg for register indexes and reset values
module nta_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [nta_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output nta_pkg::cfg_type            cfg
);

   logic [7:0] timeout_ff, timeout_in;
   logic [7:0] interval_ff, interval_in;
   logic       wr_hit;
   logic       reg_idx;

   assign pready  = 1'b1;
   assign wr_hit  = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   // write decode
   always_comb begin
      timeout_in  = timeout_ff;
      interval_in = interval_ff;
      if (wr_hit) begin
         case (reg_idx)
            nta_pkg::REG_TIMEOUT:  timeout_in  = pwdata[7:0];
            nta_pkg::REG_INTERVAL: interval_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= nta_pkg::TIMEOUT_RST;
         interval_ff <= nta_pkg::INTERVAL_RST;
      end else begin
         timeout_ff  <= timeout_in;
         interval_ff <= interval_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         nta_pkg::REG_TIMEOUT:  prdata = {24'd0, timeout_ff};
         nta_pkg::REG_INTERVAL: prdata = {24'd0, interval_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.timeout  = timeout_ff;
   assign cfg.interval = interval_ff;

endmodule

### rtl/core/nta_engine.sv
// sweep engine: walks the entry memory for hello lookup and tick aging,
// holds valid bits, interface counts, seconds clock and lsu state
// depends on nta_pkg, nta_entry_mem and the assertion macro header
`include "neighbor_table_with_aging_core_assert.svh"

module nta_engine #(
   parameter int TABLE_SLOTS = 16,
   parameter int IFACE_COUNT = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  nta_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  nta_pkg::item_type  req_item,
   input  logic               out_free,
   output logic               res_valid,
   output nta_pkg::rsp_type   res
);

   localparam int              AW       = $clog2(TABLE_SLOTS);
   localparam int              CW       = AW + 1;
   localparam logic [AW-1:0]   LAST_IDX = AW'(TABLE_SLOTS - 1);
   localparam logic [CW-1:0]   SLOTS_C  = CW'(TABLE_SLOTS);

   nta_pkg::state_type  state_ff, state_in;
   nta_pkg::item_type   item_ff, item_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                proc_vld_ff, proc_vld_in;
   logic [AW-1:0]       proc_idx_ff, proc_idx_in;
   logic                hit_ff, hit_in;
   logic                free_ok_ff, free_ok_in;
   logic [AW-1:0]       free_idx_ff, free_idx_in;
   logic [4:0]          removed_ff, removed_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [4:0]          count_ff [IFACE_COUNT];
   logic [4:0]          count_in [IFACE_COUNT];
   logic [7:0]          sec_ff, sec_in;
   logic [7:0]          cdown_ff, cdown_in;
   logic [15:0]         seq_ff, seq_in;
   nta_pkg::rsp_type    res_ff, res_in;

   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   nta_pkg::entry_type  mem_rd_data;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   nta_pkg::entry_type  mem_wr_data;

   logic                proc_valid;
   logic [7:0]          age;
   logic [4:0]          cnt_sel;
   logic [4:0]          cnt_inc;
   logic                iface_ok;
   logic                req_fire;
   logic [CW-1:0]       proc_next;

   nta_entry_mem #(
      .DEPTH (TABLE_SLOTS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // helpers for the slot under compare
   assign proc_valid = valid_ff[proc_idx_ff];
   assign age        = sec_ff - mem_rd_data.heard;
   assign iface_ok   = int'(item_ff.ifx) < IFACE_COUNT;
   assign req_fire   = req_valid & req_ready;
   assign proc_next  = {1'b0, proc_idx_ff} + CW'(1);

   // count of the hello's interface, and its saturated increment
   always_comb begin
      cnt_sel = 5'd0;
      for (int k = 0; k < IFACE_COUNT; k++) begin
         if (int'(item_ff.ifx) == k) begin
            cnt_sel = count_ff[k];
         end
      end
      cnt_inc = (cnt_sel == nta_pkg::CNT_MAX) ? cnt_sel : cnt_sel + 5'd1;
   end

   // next state and datapath control
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      issue_in    = issue_ff;
      proc_vld_in = 1'b0;
      proc_idx_in = proc_idx_ff;
      hit_in      = hit_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      removed_in  = removed_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      sec_in      = sec_ff;
      cdown_in    = cdown_ff;
      seq_in      = seq_ff;
      res_in      = res_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = issue_ff[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = proc_idx_ff;
      mem_wr_data = mem_rd_data;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         nta_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in     = req_item;
               issue_in    = '0;
               hit_in      = 1'b0;
               free_ok_in  = 1'b0;
               free_idx_in = '0;
               removed_in  = 5'd0;
               if (req_item.cmd == nta_pkg::CMD_TICK) begin
                  sec_in   = sec_ff + 8'd1;
                  state_in = nta_pkg::S_SCAN;
               end else if (int'(req_item.ifx) < IFACE_COUNT) begin
                  state_in = nta_pkg::S_SCAN;
               end else begin
                  state_in = nta_pkg::S_UPDATE;
               end
            end
         end

         nta_pkg::S_SCAN: begin
            // issue one read a cycle
            mem_rd_en   = issue_ff < SLOTS_C;
            proc_vld_in = mem_rd_en;
            proc_idx_in = issue_ff[AW-1:0];
            if (mem_rd_en) begin
               issue_in = issue_ff + CW'(1);
            end
            // compare the slot read last cycle
            if (proc_vld_ff) begin
               if (item_ff.cmd == nta_pkg::CMD_HELLO) begin
                  if (proc_valid && !hit_ff && mem_rd_data.iface == item_ff.ifx &&
                      mem_rd_data.rid == item_ff.rid) begin
                     hit_in            = 1'b1;
                     mem_wr_en         = 1'b1;
                     mem_wr_data.heard = sec_ff;
                  end
                  if (!proc_valid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = proc_idx_ff;
                  end
               end else if (proc_valid && age >= cfg.timeout) begin
                  valid_in[proc_idx_ff] = 1'b0;
                  if (removed_ff != nta_pkg::CNT_MAX) begin
                     removed_in = removed_ff + 5'd1;
                  end
                  for (int k = 0; k < IFACE_COUNT; k++) begin
                     if (int'(mem_rd_data.iface) == k && count_ff[k] != 5'd0) begin
                        count_in[k] = count_ff[k] - 5'd1;
                     end
                  end
               end
               if (proc_idx_ff == LAST_IDX) begin
                  state_in = nta_pkg::S_UPDATE;
               end
            end
         end

         nta_pkg::S_UPDATE: begin
            res_in.send    = 1'b0;
            res_in.count   = 5'd0;
            res_in.removed = 5'd0;
            if (item_ff.cmd == nta_pkg::CMD_TICK) begin
               res_in.status  = nta_pkg::ST_TICK;
               res_in.removed = removed_ff;
               if (cdown_ff <= 8'd1) begin
                  seq_in      = seq_ff + 16'd1;
                  cdown_in    = cfg.interval;
                  res_in.send = 1'b1;
               end else begin
                  cdown_in = cdown_ff - 8'd1;
               end
            end else if (!iface_ok) begin
               res_in.status = nta_pkg::ST_FULL;
            end else if (hit_ff) begin
               res_in.status = nta_pkg::ST_REFRESHED;
               res_in.count  = cnt_sel;
            end else if (free_ok_ff) begin
               // insert into the lowest free slot
               mem_wr_en         = 1'b1;
               mem_wr_addr       = free_idx_ff;
               mem_wr_data.iface = item_ff.ifx;
               mem_wr_data.rid   = item_ff.rid;
               mem_wr_data.addr  = item_ff.addr;
               mem_wr_data.mask  = item_ff.mask;
               mem_wr_data.heard = sec_ff;
               valid_in[free_idx_ff] = 1'b1;
               for (int k = 0; k < IFACE_COUNT; k++) begin
                  if (int'(item_ff.ifx) == k) begin
                     count_in[k] = cnt_inc;
                  end
               end
               seq_in        = seq_ff + 16'd1;
               cdown_in      = cfg.interval;
               res_in.status = nta_pkg::ST_ADDED;
               res_in.send   = 1'b1;
               res_in.count  = cnt_inc;
            end else begin
               res_in.status = nta_pkg::ST_FULL;
               res_in.count  = cnt_sel;
            end
            res_in.seq = seq_in;
            state_in   = nta_pkg::S_DONE;
         end

         nta_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = nta_pkg::S_IDLE;
            end
         end

         default: state_in = nta_pkg::S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= nta_pkg::S_IDLE;
         proc_vld_ff <= 1'b0;
         valid_ff    <= '0;
         sec_ff      <= 8'd0;
         cdown_ff    <= nta_pkg::INTERVAL_RST;
         seq_ff      <= 16'd0;
         for (int k = 0; k < IFACE_COUNT; k++) begin
            count_ff[k] <= 5'd0;
         end
      end else begin
         state_ff    <= state_in;
         proc_vld_ff <= proc_vld_in;
         valid_ff    <= valid_in;
         sec_ff      <= sec_in;
         cdown_ff    <= cdown_in;
         seq_ff      <= seq_in;
         count_ff    <= count_in;
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      issue_ff    <= issue_in;
      proc_idx_ff <= proc_idx_in;
      hit_ff      <= hit_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      removed_ff  <= removed_in;
      res_ff      <= res_in;
   end

   assign res = res_ff;

   // checks
   `NTA_ASSERT_IMP(a_rw_apart, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "entry memory read and write hit the same slot")
   `NTA_ASSERT_IMP(a_insert_free, mem_wr_en && state_ff == nta_pkg::S_UPDATE, !valid_ff[mem_wr_addr], "insert overwrote a valid entry")
   `NTA_ASSERT_IMP(a_sweep_step, proc_vld_ff && state_ff == nta_pkg::S_SCAN, issue_ff == proc_next, "sweep read and compare pointers out of step")
   `NTA_ASSERT_NXT(a_busy_after_accept, req_fire, state_ff != nta_pkg::S_IDLE, "engine idle right after accepting a word")

endmodule

### rtl/core/neighbor_table_with_aging_core.sv
// Neighbor table with aging: top level.
// Request channel (req_): one word per hello or one second tick; tuser is the
// command (0 hello, 1 tick), tdata carries interface, router id, address and
// mask. Response channel (rsp_): exactly one word per request, in order;
// tuser is the status, tdata carries the lsu flag, sequence, interface count
// and aged-out count. Configuration (csr_): apb-style, timeout at 0x0 and lsu
// interval at 0x4, to be written by the user only while the block is idle; the
// block itself does not enforce this. Every request walks all TABLE_SLOTS
// entries of the entry memory, one slot a cycle through its single read port;
// a hello on an interface beyond IFACE_COUNT skips the walk.
// One request is in work at a time; the next one is taken as soon as the
// previous response sits in the output register.
// Reset clears all valid bits, counts, the seconds clock and the sequence and
// reloads the lsu countdown; no clearing pass is needed. If rsp_tready is low
// the response holds in the output register and the engine, once finished
// with the next word, waits for the register to drain.
module neighbor_table_with_aging_core #(
   parameter int TABLE_SLOTS = 16,
   parameter int IFACE_COUNT = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: iface_index[1:0], neighbor_rid[33:2], neighbor_addr[65:34],
   // neighbor_netmask[97:66], zero fill above
   input  logic [nta_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: cmd
   input  logic                             req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: lsu_trigger[0], lsu_seq[16:1], iface_neighbor_count[21:17],
   // removed_count[26:22], zero fill above
   output logic [nta_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tuser: status
   output logic [1:0]                       rsp_tuser,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nta_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   nta_pkg::cfg_type   cfg;
   nta_pkg::item_type  item;
   nta_pkg::rsp_type   res;
   logic               res_valid;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   nta_pkg::rsp_type   rsp_ff, rsp_in;

   nta_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // unpack the request word
   assign item.cmd  = req_tuser;
   assign item.ifx  = req_tdata[1:0];
   assign item.rid  = req_tdata[33:2];
   assign item.addr = req_tdata[65:34];
   assign item.mask = req_tdata[97:66];

   nta_engine #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IFACE_COUNT (IFACE_COUNT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (item),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // pack the response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {5'd0, rsp_ff.removed, rsp_ff.count, rsp_ff.seq, rsp_ff.send};

endmodule

### tb/tb_neighbor_table_with_aging_core.sv
`timescale 1ns / 1ps
// self-checking testbench for neighbor_table_with_aging_core: hello and tick
// words go in on the req_ stream, results are checked against a local predictor
// depends on nta_pkg and the core rtl only
module tb_neighbor_table_with_aging_core;

   localparam int NBR_SLOTS        = 16;
   localparam int NBR_IFACES       = 4;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_AT     = 350;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 40;
   localparam logic [nta_pkg::CSR_AW-1:0] ADDR_TIMEOUT  = {nta_pkg::REG_TIMEOUT, 2'b00};
   localparam logic [nta_pkg::CSR_AW-1:0] ADDR_INTERVAL = {nta_pkg::REG_INTERVAL, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // tdata: iface_index, neighbor_rid, neighbor_addr, neighbor_netmask, zero fill
   logic [nta_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;
   // tuser: cmd
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // tdata: lsu_trigger, lsu_seq, iface_neighbor_count, removed_count, zero fill
   logic [nta_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   // tuser: status
   logic [1:0]                       rsp_tuser;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [nta_pkg::CSR_AW-1:0]       csr_paddr = '0;
   logic [31:0]                      csr_pwdata = '0;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   neighbor_table_with_aging_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shared bookkeeping
   nta_pkg::item_type hello_tick_q[$];
   nta_pkg::rsp_type  predicted_rsp_q[$];
   int                error_count = 0;
   bit                quiet_run = 1'b0;

   // predicted table state; addr and mask never reach the outputs
   bit          tbl_valid [NBR_SLOTS];
   logic [1:0]  tbl_iface [NBR_SLOTS];
   logic [31:0] tbl_rid   [NBR_SLOTS];
   logic [7:0]  tbl_heard [NBR_SLOTS];
   logic [4:0]  nbr_count [NBR_IFACES];
   logic [7:0]  sec_now;
   logic [7:0]  lsu_countdown_m;
   logic [15:0] lsu_seq_m;
   logic [7:0]  cfg_timeout;
   logic [7:0]  cfg_interval;

   task automatic clear_neighbor_model();
      for (int k = 0; k < NBR_SLOTS; k++) tbl_valid[k] = 1'b0;
      for (int k = 0; k < NBR_IFACES; k++) nbr_count[k] = '0;
      sec_now = '0;
      cfg_timeout = nta_pkg::TIMEOUT_RST;
      cfg_interval = nta_pkg::INTERVAL_RST;
      lsu_countdown_m = nta_pkg::INTERVAL_RST;
      lsu_seq_m = '0;
   endtask

   task automatic fire_lsu();
      lsu_seq_m = lsu_seq_m + 16'd1;
      lsu_countdown_m = cfg_interval;
   endtask

   // work out the result of one accepted word and queue it
   task automatic predict_neighbor_result(input nta_pkg::item_type it);
      nta_pkg::rsp_type r;
      bit               hit;
      int               free_slot;
      logic [7:0]       age;
      r = '0;
      if (it.cmd == nta_pkg::CMD_HELLO) begin
         hit = 1'b0;
         free_slot = -1;
         for (int k = 0; k < NBR_SLOTS; k++) begin
            if (tbl_valid[k]) begin
               if (!hit && tbl_iface[k] == it.ifx && tbl_rid[k] == it.rid) begin
                  tbl_heard[k] = sec_now;
                  hit = 1'b1;
               end
            end else if (free_slot < 0) begin
               free_slot = k;
            end
         end
         if (hit) begin
            r.status = nta_pkg::ST_REFRESHED;
         end else if (free_slot >= 0) begin
            tbl_valid[free_slot] = 1'b1;
            tbl_iface[free_slot] = it.ifx;
            tbl_rid[free_slot] = it.rid;
            tbl_heard[free_slot] = sec_now;
            if (nbr_count[it.ifx] < nta_pkg::CNT_MAX)
               nbr_count[it.ifx] = nbr_count[it.ifx] + 5'd1;
            fire_lsu();
            r.send = 1'b1;
            r.status = nta_pkg::ST_ADDED;
         end else begin
            r.status = nta_pkg::ST_FULL;
         end
         r.count = nbr_count[it.ifx];
      end else begin
         r.status = nta_pkg::ST_TICK;
         sec_now = sec_now + 8'd1;
         // age out with the wrapped difference
         for (int k = 0; k < NBR_SLOTS; k++) begin
            age = sec_now - tbl_heard[k];
            if (tbl_valid[k] && age >= cfg_timeout) begin
               tbl_valid[k] = 1'b0;
               if (nbr_count[tbl_iface[k]] > 0)
                  nbr_count[tbl_iface[k]] = nbr_count[tbl_iface[k]] - 5'd1;
               if (r.removed < nta_pkg::CNT_MAX) r.removed = r.removed + 5'd1;
            end
         end
         if (lsu_countdown_m <= 8'd1) begin
            fire_lsu();
            r.send = 1'b1;
         end else begin
            lsu_countdown_m = lsu_countdown_m - 8'd1;
         end
      end
      r.seq = lsu_seq_m;
      predicted_rsp_q.push_back(r);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // request driver with random idle bursts
   nta_pkg::item_type offered;
   int                req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_neighbor_result(offered);
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (hello_tick_q.size() != 0) begin
               if (!quiet_run && $urandom_range(0, 7) == 0) begin
                  req_gap <= $urandom_range(0, 10);
                  req_tvalid <= 1'b0;
               end else begin
                  offered = hello_tick_q.pop_front();
                  req_tdata <= {6'b0, offered.mask, offered.addr, offered.rid, offered.ifx};
                  req_tuser <= offered.cmd;
                  req_tvalid <= 1'b1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor, also owns rsp_tready and the long hold-off
   nta_pkg::rsp_type want_rsp;
   int               rsp_seen = 0;
   int               hold_left = 0;
   bit               long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (predicted_rsp_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, got status %0h tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want_rsp = predicted_rsp_q.pop_front();
               check_field("status", want_rsp.status, rsp_tuser);
               check_field("lsu_trigger", want_rsp.send, rsp_tdata[0]);
               check_field("lsu_seq", want_rsp.seq, rsp_tdata[16:1]);
               check_field("iface_neighbor_count", want_rsp.count, rsp_tdata[21:17]);
               check_field("removed_count", want_rsp.removed, rsp_tdata[26:22]);
               check_field("tdata fill", 0, rsp_tdata[31:27]);
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_seen >= LONG_HOLD_AT && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
            hold_left <= $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_neighbor_table_with_aging_core: done, errors");
         $finish;
      end
   end

   // stimulus helpers
   task automatic push_hello(input logic [1:0] ifx, input logic [31:0] rid,
                             input logic [31:0] addr, input logic [31:0] mask);
      nta_pkg::item_type it;
      it.cmd = nta_pkg::CMD_HELLO;
      it.ifx = ifx;
      it.rid = rid;
      it.addr = addr;
      it.mask = mask;
      hello_tick_q.push_back(it);
   endtask

   // tick words carry random junk in the ignored fields
   task automatic push_tick();
      nta_pkg::item_type it;
      it.cmd = nta_pkg::CMD_TICK;
      it.ifx = 2'($urandom);
      it.rid = $urandom;
      it.addr = $urandom;
      it.mask = $urandom;
      hello_tick_q.push_back(it);
   endtask

   task automatic wait_idle();
      while (hello_tick_q.size() != 0 || req_tvalid || predicted_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [nta_pkg::CSR_AW-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_TIMEOUT) cfg_timeout = data[7:0];
      else if (addr == ADDR_INTERVAL) cfg_interval = data[7:0];
   endtask

   // mostly hellos from a small neighbor pool so refresh and full both happen
   task automatic run_random(input int n, input int pool_size, input int tick_pct,
                             input logic [7:0] timeout, input logic [7:0] interval);
      logic [31:0] rid_pool [32];
      int          roll;
      int          k;
      wait_idle();
      csr_write(ADDR_TIMEOUT, {24'b0, timeout});
      csr_write(ADDR_INTERVAL, {24'b0, interval});
      for (int i = 0; i < 32; i++) rid_pool[i] = $urandom;
      rid_pool[0] = 32'h0;
      rid_pool[1] = 32'hFFFF_FFFF;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         k = $urandom_range(0, pool_size - 1);
         if (roll < tick_pct)
            push_tick();
         else if (roll < tick_pct + 6)
            push_hello(2'($urandom), $urandom, $urandom, $urandom);
         else if (roll < tick_pct + 12)
            push_hello(2'($urandom), rid_pool[k], $urandom, $urandom);
         else
            push_hello(2'(k), rid_pool[k], $urandom, $urandom);
      end
   endtask

   initial begin
      clear_neighbor_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, refresh, same router id on another interface, full table
      push_hello(2'd0, 32'h0, 32'h0, 32'h0);
      push_hello(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_hello(2'd0, 32'h0, 32'h1234_5678, 32'hFFFF_FF00);
      push_hello(2'd1, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      push_tick();
      for (int i = 0; i < 13; i++)
         push_hello(2'd2, 32'h100 + i, $urandom, $urandom);
      push_hello(2'd2, 32'hDEAD_0001, $urandom, $urandom);
      push_hello(2'd0, 32'h0, $urandom, $urandom);
      wait_idle();
      // a timeout of 1 ages the whole table out on one tick
      csr_write(ADDR_TIMEOUT, 32'd1);
      push_tick();
      push_hello(2'd1, 32'h5, $urandom, $urandom);
      push_tick();

      // random phases, extremes of both registers first
      run_random(250, 24, 20, 8'd255, 8'd255);
      run_random(200, 8, 50, 8'd1, 8'd1);
      for (int p = 0; p < 5; p++)
         run_random(180, 20, 40, 8'($urandom_range(2, 40)), 8'($urandom_range(1, 20)));
      wait_idle();
      quiet_run = 1'b1;
      run_random(200, 16, 35, 8'd6, 8'd3);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_neighbor_table_with_aging_core: done, clean");
      end else begin
         $display("tb_neighbor_table_with_aging_core: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/nta_pkg.sv
rtl/core/nta_entry_mem.sv
rtl/core/nta_csr.sv
rtl/core/nta_engine.sv
rtl/core/neighbor_table_with_aging_core.sv
tb/tb_neighbor_table_with_aging_core.sv
